// ===== design/wce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wce_pkg;

    localparam int DEF_MAX_DIM     = 8;
    localparam int DEF_MAX_SAMPLES = 256;

    localparam int SAMPLE_W = 16;
    localparam int TOT_W    = 24;
    localparam int VAL_W    = 48;
    localparam int MEAN_W   = 17;

    localparam logic [1:0] FN_LOAD   = 2'd0;
    localparam logic [1:0] FN_FINISH = 2'd1;
    localparam logic [1:0] FN_MEAN   = 2'd2;
    localparam logic [1:0] FN_MATRIX = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO_WT = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_FIN_EMPTY,
        OP_FIN_START,
        OP_WSUM,
        OP_CLEAR,
        OP_ACC_CLR,
        OP_MEAN_ACC,
        OP_DEV_K,
        OP_PROD,
        OP_MAT_ACC,
        OP_DIV_START,
        OP_MEAN_WR,
        OP_MAT_WR,
        OP_RES_CONST,
        OP_RES_MEAN,
        OP_RES_MAT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       capture;
        logic       div_mean;
        logic [1:0] res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic tot_zero;
        logic div_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/wce_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/wce_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wce_div #(
    parameter int DVD_W = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic signed [DVD_W-1:0]        dividend,
    input  wire logic [wce_pkg::TOT_W-1:0]      divisor,
    output logic                                busy,
    output logic signed [DVD_W-1:0]             quotient
);

    localparam int CW = $clog2(DVD_W + 1);
    localparam int TW = wce_pkg::TOT_W;

    logic              busy_reg, busy_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [TW-1:0]     rem_reg, rem_next;
    logic [TW-1:0]     dvs_reg, dvs_next;
    logic [TW:0]       rem_sh;
    logic              ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DVD_W-1]};
        ge        = (rem_sh >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DVD_W);
            neg_next  = dividend[DVD_W-1];
            quo_next  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? TW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[TW-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

`default_nettype wire

// ===== design/wce_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wce_dp #(
    parameter int MAX_DIM     = wce_pkg::DEF_MAX_DIM,
    parameter int MAX_SAMPLES = wce_pkg::DEF_MAX_SAMPLES,
    localparam int IDXW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int DIMW = $clog2(MAX_DIM + 1),
    localparam int WAW  = $clog2(MAX_SAMPLES),
    localparam int CNTW = $clog2(MAX_SAMPLES + 1)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire wce_pkg::dp_cmd_t        cmd,
    input  wire logic [WAW-1:0]          s_idx,
    input  wire logic [IDXW-1:0]         e_idx,
    input  wire logic [IDXW-1:0]         mean_idx,
    input  wire logic [IDXW-1:0]         k_idx,
    input  wire logic [IDXW-1:0]         j_idx,
    input  wire logic [DIMW-1:0]         act_dim,
    input  wire logic                    use_weights,
    input  wire logic                    normalize,
    input  wire logic                    byte_samples,
    input  wire logic signed [15:0]      sample_value,
    input  wire logic [15:0]             sample_weight,
    input  wire logic [2:0]              row_index,
    input  wire logic [2:0]              column_index,
    output wce_pkg::dp_status_t          stat,
    output logic [CNTW-1:0]              count,
    output logic signed [47:0]           result_value,
    output logic [1:0]                   status
);

    localparam int SAW   = $clog2(MAX_SAMPLES * MAX_DIM);
    localparam int MDEP  = MAX_DIM * MAX_DIM;
    localparam int MATAW = (MDEP > 1) ? $clog2(MDEP) : 1;
    localparam int ACC_W = 53 + $clog2(MAX_SAMPLES);
    localparam int TW    = wce_pkg::TOT_W;
    localparam int MW    = wce_pkg::MEAN_W;
    localparam int VW    = wce_pkg::VAL_W;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        $signed({{(ACC_W-VW+1){1'b0}}, {(VW-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic [CNTW-1:0]           count_reg, count_next;
    logic [DIMW-1:0]           pos_reg, pos_next;
    logic [TW-1:0]             tot_reg, tot_next;
    logic signed [MW-1:0]      mean_reg [MAX_DIM];
    logic [MDEP-1:0]           mvalid_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [MW:0]        dk_reg;
    logic signed [35:0]        prod_reg;
    logic signed [MW-1:0]      w_reg;
    logic [2:0]                row_reg;
    logic [2:0]                col_reg;
    logic signed [VW-1:0]      res_value_reg;
    logic [1:0]                res_status_reg;

    logic [DIMW-1:0]           pos_eff;
    logic [DIMW:0]             pos_inc;
    logic [SAW-1:0]            samp_waddr, samp_raddr;
    logic [15:0]               samp_rdata, wt_rdata;
    logic [MATAW-1:0]          mat_waddr, mat_raddr;
    logic [VW-1:0]             mat_rdata;
    logic signed [MW-1:0]      x_val, w_val, mean_q;
    logic [IDXW-1:0]           mean_addr;
    logic signed [MW:0]        dev;
    logic signed [2*MW-1:0]    mprod;
    logic signed [52:0]        term;
    logic [TW:0]               tot_sum;
    logic                      div_busy;
    logic signed [ACC_W-1:0]   quot;
    logic signed [ACC_W-1:0]   shr_q, mat_q;
    logic signed [VW-1:0]      quot_sat;
    logic                      row_ok, col_ok;
    logic                      st_zero;

    assign pos_eff    = (pos_reg >= act_dim) ? '0 : pos_reg;
    assign pos_inc    = {1'b0, pos_eff} + (DIMW+1)'(1);
    assign samp_waddr = SAW'(int'(count_reg) * MAX_DIM + int'(pos_eff));
    assign samp_raddr = SAW'(int'(s_idx) * MAX_DIM + int'(e_idx));
    assign mat_waddr  = MATAW'(int'(k_idx) * MAX_DIM + int'(j_idx));
    assign mat_raddr  = MATAW'(int'(row_reg) * MAX_DIM + int'(col_reg));

    wce_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES * MAX_DIM)) u_samp_ram (
        .clk   (clk),
        .we    (cmd.op == wce_pkg::OP_LOAD),
        .waddr (samp_waddr),
        .wdata (sample_value),
        .raddr (samp_raddr),
        .rdata (samp_rdata)
    );

    wce_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_wt_ram (
        .clk   (clk),
        .we    ((cmd.op == wce_pkg::OP_LOAD) && (pos_eff == '0)),
        .waddr (count_reg[WAW-1:0]),
        .wdata (sample_weight),
        .raddr (s_idx),
        .rdata (wt_rdata)
    );

    wce_ram #(.WIDTH(VW), .DEPTH(MDEP)) u_mat_ram (
        .clk   (clk),
        .we    (cmd.op == wce_pkg::OP_MAT_WR),
        .waddr (mat_waddr),
        .wdata (quot_sat),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    wce_div #(.DVD_W(ACC_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((cmd.op == wce_pkg::OP_DIV_START) && (cmd.div_mean || normalize)),
        .dividend (acc_reg),
        .divisor  (tot_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    always_comb
    begin
        x_val = byte_samples ? $signed({1'b0, samp_rdata[7:0], 8'h00})
                             : $signed({samp_rdata[15], samp_rdata});
        w_val = use_weights ? $signed({1'b0, wt_rdata}) : MW'(256);
        mean_addr = (cmd.op == wce_pkg::OP_RES_MEAN) ? IDXW'(row_reg) : mean_idx;
        mean_q  = mean_reg[mean_addr];
        dev     = {x_val[MW-1], x_val} - {mean_q[MW-1], mean_q};
        mprod   = x_val * w_val;
        term    = prod_reg * w_reg;
        tot_sum = {1'b0, tot_reg} + (TW+1)'(use_weights ? wt_rdata : 16'd256);
        // divide by 256 rounding toward zero
        shr_q   = (acc_reg + (acc_reg[ACC_W-1] ? $signed(ACC_W'(255))
                                               : $signed(ACC_W'(0)))) >>> 8;
        mat_q   = normalize ? quot : shr_q;
        if (mat_q > SAT_HI)
        begin
            quot_sat = {1'b0, {(VW-1){1'b1}}};
        end
        else if (mat_q < SAT_LO)
        begin
            quot_sat = {1'b1, {(VW-1){1'b0}}};
        end
        else
        begin
            quot_sat = mat_q[VW-1:0];
        end
        row_ok  = (int'(row_reg) < MAX_DIM);
        col_ok  = (int'(col_reg) < MAX_DIM);
        st_zero = (tot_reg == '0);
    end

    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        tot_next   = tot_reg;
        case (cmd.op)
            wce_pkg::OP_LOAD:
            begin
                if (pos_inc >= {1'b0, act_dim})
                begin
                    pos_next   = '0;
                    count_next = count_reg + CNTW'(1);
                end
                else
                begin
                    pos_next = pos_inc[DIMW-1:0];
                end
            end
            wce_pkg::OP_FIN_EMPTY:
            begin
                pos_next = '0;
            end
            wce_pkg::OP_FIN_START:
            begin
                pos_next   = '0;
                count_next = '0;
                tot_next   = '0;
            end
            wce_pkg::OP_WSUM:
            begin
                tot_next = tot_sum[TW] ? {TW{1'b1}} : tot_sum[TW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pos_reg    <= '0;
            tot_reg    <= '0;
            mvalid_reg <= '0;
            for (int i = 0; i < MAX_DIM; i++)
            begin
                mean_reg[i] <= '0;
            end
        end
        else
        begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
            tot_reg   <= tot_next;
            if (cmd.op == wce_pkg::OP_CLEAR)
            begin
                mvalid_reg <= '0;
                for (int i = 0; i < MAX_DIM; i++)
                begin
                    mean_reg[i] <= '0;
                end
            end
            if (cmd.op == wce_pkg::OP_MEAN_WR)
            begin
                mean_reg[mean_idx] <= MW'(quot);
            end
            if (cmd.op == wce_pkg::OP_MAT_WR)
            begin
                mvalid_reg[mat_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= row_index;
            col_reg <= column_index;
        end
        case (cmd.op)
            wce_pkg::OP_ACC_CLR:  acc_reg <= '0;
            wce_pkg::OP_MEAN_ACC: acc_reg <= acc_reg + ACC_W'(mprod);
            wce_pkg::OP_MAT_ACC:  acc_reg <= acc_reg + ACC_W'(term);
            default:
            begin
            end
        endcase
        if (cmd.op == wce_pkg::OP_DEV_K)
        begin
            dk_reg <= dev;
        end
        if (cmd.op == wce_pkg::OP_PROD)
        begin
            prod_reg <= dk_reg * dev;
            w_reg    <= w_val;
        end
        case (cmd.op)
            wce_pkg::OP_RES_CONST:
            begin
                res_value_reg  <= '0;
                res_status_reg <= cmd.res_status;
            end
            wce_pkg::OP_RES_MEAN:
            begin
                res_value_reg  <= row_ok ? (VW'(mean_q) <<< 8) : '0;
                res_status_reg <= st_zero ? wce_pkg::ST_ZERO_WT : wce_pkg::ST_OK;
            end
            wce_pkg::OP_RES_MAT:
            begin
                res_value_reg  <= (row_ok && col_ok && mvalid_reg[mat_raddr])
                                  ? $signed(mat_rdata) : '0;
                res_status_reg <= st_zero ? wce_pkg::ST_ZERO_WT : wce_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.full     = (int'(count_reg) >= MAX_SAMPLES);
    assign stat.empty    = (count_reg == '0);
    assign stat.tot_zero = st_zero;
    assign stat.div_busy = div_busy;
    assign count         = count_reg;
    assign result_value  = res_value_reg;
    assign status        = res_status_reg;

endmodule

`default_nettype wire

// ===== design/wce_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wce_ctrl #(
    parameter int MAX_DIM     = wce_pkg::DEF_MAX_DIM,
    parameter int MAX_SAMPLES = wce_pkg::DEF_MAX_SAMPLES,
    localparam int IDXW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int DIMW = $clog2(MAX_DIM + 1),
    localparam int WAW  = $clog2(MAX_SAMPLES),
    localparam int CNTW = $clog2(MAX_SAMPLES + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           func,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire logic [DIMW-1:0]      act_dim,
    input  wire wce_pkg::dp_status_t  stat,
    input  wire logic [CNTW-1:0]      count,
    output wce_pkg::dp_cmd_t          cmd,
    output logic [WAW-1:0]            s_idx,
    output logic [IDXW-1:0]           e_idx,
    output logic [IDXW-1:0]           mean_idx,
    output logic [IDXW-1:0]           k_idx,
    output logic [IDXW-1:0]           j_idx
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_WS_RD,
        S_WS_ACC,
        S_WS_END,
        S_MN_START,
        S_MN_RD,
        S_MN_ACC,
        S_MN_DIV,
        S_MN_WAIT,
        S_MX_START,
        S_MX_RK,
        S_MX_RJ,
        S_MX_PROD,
        S_MX_ACC,
        S_MX_DIV,
        S_MX_WAIT,
        S_DLV,
        S_DLV_MEAN,
        S_RD_MAT,
        S_DLV_MAT
    } state_t;

    state_t           state_reg, state_next;
    logic [WAW-1:0]   s_reg, s_next;
    logic [IDXW-1:0]  k_reg, k_next;
    logic [IDXW-1:0]  j_reg, j_next;
    logic [CNTW-1:0]  n_reg, n_next;
    logic [1:0]       st_reg, st_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             s_last, k_last, j_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign s_last   = ((CNTW'(s_reg) + CNTW'(1)) == n_reg);
    assign k_last   = ((DIMW'(k_reg) + DIMW'(1)) == act_dim);
    assign j_last   = ((DIMW'(j_reg) + DIMW'(1)) == act_dim);

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = wce_pkg::OP_NONE;
        cmd.capture    = (state_reg == S_IDLE);
        cmd.div_mean   = 1'b0;
        cmd.res_status = st_reg;
        e_idx          = k_reg;
        mean_idx       = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func)
                        wce_pkg::FN_LOAD:
                        begin
                            if (stat.full)
                            begin
                                st_next    = wce_pkg::ST_EMPTY;
                                state_next = S_DLV;
                            end
                            else
                            begin
                                cmd.op = wce_pkg::OP_LOAD;
                            end
                        end
                        wce_pkg::FN_FINISH:
                        begin
                            if (stat.empty)
                            begin
                                cmd.op     = wce_pkg::OP_FIN_EMPTY;
                                st_next    = wce_pkg::ST_EMPTY;
                                state_next = S_DLV;
                            end
                            else
                            begin
                                cmd.op     = wce_pkg::OP_FIN_START;
                                n_next     = count;
                                s_next     = '0;
                                state_next = S_WS_RD;
                            end
                        end
                        wce_pkg::FN_MEAN:   state_next = S_DLV_MEAN;
                        wce_pkg::FN_MATRIX: state_next = S_RD_MAT;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_WS_RD:
            begin
                state_next = S_WS_ACC;
            end
            S_WS_ACC:
            begin
                cmd.op = wce_pkg::OP_WSUM;
                if (s_last)
                begin
                    state_next = S_WS_END;
                end
                else
                begin
                    s_next     = s_reg + WAW'(1);
                    state_next = S_WS_RD;
                end
            end
            S_WS_END:
            begin
                cmd.op = wce_pkg::OP_CLEAR;
                if (stat.tot_zero)
                begin
                    st_next    = wce_pkg::ST_ZERO_WT;
                    state_next = S_DLV;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_MN_START;
                end
            end
            S_MN_START:
            begin
                cmd.op     = wce_pkg::OP_ACC_CLR;
                s_next     = '0;
                state_next = S_MN_RD;
            end
            S_MN_RD:
            begin
                state_next = S_MN_ACC;
            end
            S_MN_ACC:
            begin
                cmd.op = wce_pkg::OP_MEAN_ACC;
                if (s_last)
                begin
                    state_next = S_MN_DIV;
                end
                else
                begin
                    s_next     = s_reg + WAW'(1);
                    state_next = S_MN_RD;
                end
            end
            S_MN_DIV:
            begin
                cmd.op       = wce_pkg::OP_DIV_START;
                cmd.div_mean = 1'b1;
                state_next   = S_MN_WAIT;
            end
            S_MN_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op = wce_pkg::OP_MEAN_WR;
                    if (k_last)
                    begin
                        k_next     = '0;
                        j_next     = '0;
                        state_next = S_MX_START;
                    end
                    else
                    begin
                        k_next     = k_reg + IDXW'(1);
                        state_next = S_MN_START;
                    end
                end
            end
            S_MX_START:
            begin
                cmd.op     = wce_pkg::OP_ACC_CLR;
                s_next     = '0;
                state_next = S_MX_RK;
            end
            S_MX_RK:
            begin
                state_next = S_MX_RJ;
            end
            S_MX_RJ:
            begin
                cmd.op     = wce_pkg::OP_DEV_K;
                e_idx      = j_reg;
                state_next = S_MX_PROD;
            end
            S_MX_PROD:
            begin
                cmd.op     = wce_pkg::OP_PROD;
                e_idx      = j_reg;
                mean_idx   = j_reg;
                state_next = S_MX_ACC;
            end
            S_MX_ACC:
            begin
                cmd.op = wce_pkg::OP_MAT_ACC;
                if (s_last)
                begin
                    state_next = S_MX_DIV;
                end
                else
                begin
                    s_next     = s_reg + WAW'(1);
                    state_next = S_MX_RK;
                end
            end
            S_MX_DIV:
            begin
                cmd.op     = wce_pkg::OP_DIV_START;
                state_next = S_MX_WAIT;
            end
            S_MX_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op = wce_pkg::OP_MAT_WR;
                    if (j_last)
                    begin
                        if (k_last)
                        begin
                            st_next    = wce_pkg::ST_OK;
                            state_next = S_DLV;
                        end
                        else
                        begin
                            k_next     = k_reg + IDXW'(1);
                            j_next     = '0;
                            state_next = S_MX_START;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + IDXW'(1);
                        state_next = S_MX_START;
                    end
                end
            end
            S_DLV:
            begin
                if (out_free)
                begin
                    cmd.op         = wce_pkg::OP_RES_CONST;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DLV_MEAN:
            begin
                if (out_free)
                begin
                    cmd.op         = wce_pkg::OP_RES_MEAN;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD_MAT:
            begin
                state_next = S_DLV_MAT;
            end
            S_DLV_MAT:
            begin
                if (out_free)
                begin
                    cmd.op         = wce_pkg::OP_RES_MAT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            s_reg         <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            st_reg        <= wce_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign s_idx     = s_reg;
    assign k_idx     = k_reg;
    assign j_idx     = j_reg;

endmodule

`default_nettype wire

// ===== design/weighted_covariance_engine_unit.sv =====
// channel | direction | transfer when        | payload
// in      | into      | in_valid & !in_stall | func, sample_value, sample_weight,
//         |           |                      | row_index, column_index
// out     | out of    | out_valid & !out_stall | result_value, status
// cfg     | into      | psel & penable & pwrite | paddr, pwdata (prdata on read)
//
// loads are taken back to back until the memory is full; finish sums the weights, then
// for d dimensions accumulates and divides d means and d*d matrix entries, as paced by
// the single read port of the sample memory and the radix-2 divider; unnormalised,
// matrix entries are shifted rather than divided
// reset clears control state, mean and matrix validity; no memory clearing pass
// a stalled result holds in the output register while the next item is taken
`timescale 1ns / 1ps
`default_nettype none

module weighted_covariance_engine_unit #(
    parameter int MAX_DIM     = wce_pkg::DEF_MAX_DIM,
    parameter int MAX_SAMPLES = wce_pkg::DEF_MAX_SAMPLES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic signed [15:0] sample_value,
    input  wire logic [15:0]        sample_weight,
    input  wire logic [2:0]         row_index,
    input  wire logic [2:0]         column_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [47:0]      result_value,
    output logic [1:0]              status,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IDXW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIMW = $clog2(MAX_DIM + 1);
    localparam int WAW  = $clog2(MAX_SAMPLES);
    localparam int CNTW = $clog2(MAX_SAMPLES + 1);

    localparam logic [1:0] REG_DIMENSION   = 2'd0;
    localparam logic [1:0] REG_USE_WEIGHTS = 2'd1;
    localparam logic [1:0] REG_NORMALIZE   = 2'd2;
    localparam logic [1:0] REG_BYTE        = 2'd3;

    logic [3:0]           dimension_reg;
    logic                 use_weights_reg;
    logic                 normalize_reg;
    logic                 byte_samples_reg;
    logic                 cfg_wr;
    logic [DIMW-1:0]      act_dim;

    wce_pkg::dp_cmd_t     cmd;
    wce_pkg::dp_status_t  stat;
    logic [CNTW-1:0]      count;
    logic [WAW-1:0]       s_idx;
    logic [IDXW-1:0]      e_idx, mean_idx, k_idx, j_idx;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg    <= 4'd8;
            use_weights_reg  <= 1'b0;
            normalize_reg    <= 1'b1;
            byte_samples_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_DIMENSION:   dimension_reg    <= pwdata[3:0];
                REG_USE_WEIGHTS: use_weights_reg  <= pwdata[0];
                REG_NORMALIZE:   normalize_reg    <= pwdata[0];
                REG_BYTE:        byte_samples_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DIMENSION:   prdata = {28'd0, dimension_reg};
            REG_USE_WEIGHTS: prdata = {31'd0, use_weights_reg};
            REG_NORMALIZE:   prdata = {31'd0, normalize_reg};
            REG_BYTE:        prdata = {31'd0, byte_samples_reg};
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        if (dimension_reg == 4'd0)
        begin
            act_dim = DIMW'(1);
        end
        else if (int'(dimension_reg) > MAX_DIM)
        begin
            act_dim = DIMW'(MAX_DIM);
        end
        else
        begin
            act_dim = DIMW'(dimension_reg);
        end
    end

    wce_ctrl #(.MAX_DIM(MAX_DIM), .MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .act_dim   (act_dim),
        .stat      (stat),
        .count     (count),
        .cmd       (cmd),
        .s_idx     (s_idx),
        .e_idx     (e_idx),
        .mean_idx  (mean_idx),
        .k_idx     (k_idx),
        .j_idx     (j_idx)
    );

    wce_dp #(.MAX_DIM(MAX_DIM), .MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .s_idx         (s_idx),
        .e_idx         (e_idx),
        .mean_idx      (mean_idx),
        .k_idx         (k_idx),
        .j_idx         (j_idx),
        .act_dim       (act_dim),
        .use_weights   (use_weights_reg),
        .normalize     (normalize_reg),
        .byte_samples  (byte_samples_reg),
        .sample_value  (sample_value),
        .sample_weight (sample_weight),
        .row_index     (row_index),
        .column_index  (column_index),
        .stat          (stat),
        .count         (count),
        .result_value  (result_value),
        .status        (status)
    );

endmodule

`default_nettype wire
